// ===== hdl/page_lcd_box_outline_stream_defines.svh =====
// Assertion macros for the LCD box outline stream.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PAGE_LCD_BOX_OUTLINE_STREAM_DEFINES_SVH
`define PAGE_LCD_BOX_OUTLINE_STREAM_DEFINES_SVH

// same-cycle implication
`define PLBO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plbo check failed");

// next-cycle implication
`define PLBO_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plbo check failed");

`endif

// ===== hdl/plbo_pkg.sv =====
// Package for the LCD box outline stream: beat types, command constants,
// microcode ROM and helpers. No dependencies.
`timescale 1ns / 1ps

package plbo_pkg;

   localparam int COLUMNS_DEF = 128;
   localparam int PAGES_DEF   = 8;

   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] NIB_HI     = 8'hF0;
   localparam logic [7:0] NIB_LO     = 8'h0F;
   localparam logic [7:0] ALL_ROWS   = 8'hFF;
   localparam logic [7:0] TOP_BIT    = 8'h80;
   localparam logic [7:0] FLIP_OFFSET = 8'd4;

   // pass kinds
   localparam logic [1:0] PASS_TOP    = 2'd0;
   localparam logic [1:0] PASS_BOTTOM = 2'd1;
   localparam logic [1:0] PASS_MID    = 2'd2;

   // microcode steps
   localparam logic [1:0] STEP_PAGE   = 2'd0;
   localparam logic [1:0] STEP_COL_HI = 2'd1;
   localparam logic [1:0] STEP_COL_LO = 2'd2;
   localparam logic [1:0] STEP_DATA   = 2'd3;

   // byte source select
   localparam logic [1:0] SEL_PAGE   = 2'd0;
   localparam logic [1:0] SEL_COL_HI = 2'd1;
   localparam logic [1:0] SEL_COL_LO = 2'd2;
   localparam logic [1:0] SEL_PIXEL  = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [6:0] x_left;
      logic [5:0] y_top;
      logic [6:0] x_right;
      logic [5:0] y_bottom;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       is_data;
      logic       end_of_transfer;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] sel;
      logic       is_data;
      logic       eot;
      logic       jump_at_right;  // leave the step when the right column is sent
      logic [1:0] next_step;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [1:0] step);
      ucode_type w;
      case (step)
         STEP_PAGE:   w = '{SEL_PAGE,   1'b0, 1'b0, 1'b0, STEP_COL_HI};
         STEP_COL_HI: w = '{SEL_COL_HI, 1'b0, 1'b0, 1'b0, STEP_COL_LO};
         STEP_COL_LO: w = '{SEL_COL_LO, 1'b0, 1'b1, 1'b0, STEP_DATA};
         STEP_DATA:   w = '{SEL_PIXEL,  1'b1, 1'b0, 1'b1, STEP_DATA};
         default:     w = '{SEL_PAGE,   1'b0, 1'b0, 1'b0, STEP_PAGE};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7 - k] = v[k];
      end
      return r;
   endfunction

endpackage

// ===== hdl/page_lcd_box_outline_stream.sv =====
// Output: a tick beat's byte is registered and appears on rsp in the cycle after it is accepted.
// Throughput: one tick beat per cycle while rsp is not stalled; the single
//   output register holds the pending byte and stalls req only while full.
// A box costs 3 + (x_right - x_left + 1) ticks per page; start beats give no result.
// Reset (synchronous, active high) returns to idle with upside_down cleared.
// Depends on plbo_pkg and page_lcd_box_outline_stream_defines.svh.
`timescale 1ns / 1ps
`include "page_lcd_box_outline_stream_defines.svh"

module page_lcd_box_outline_stream #(
   parameter int COLUMNS = plbo_pkg::COLUMNS_DEF,
   parameter int PAGES   = plbo_pkg::PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plbo_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plbo_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);

   localparam logic [7:0] ColLimit  = 8'(COLUMNS);
   localparam logic [3:0] PageLimit = 4'(PAGES);
   localparam logic [2:0] PageTop   = 3'(PAGES - 1);

   logic       upside_ff, upside_in;
   logic       busy_ff, busy_in;
   logic [6:0] left_ff, left_in, right_ff, right_in, col_ff, col_in;
   logic [5:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [1:0] pass_ff, pass_in, step_ff, step_in;
   logic [2:0] page_ff, page_in;
   logic       rsp_valid_ff, rsp_valid_in;
   plbo_pkg::rsp_type rsp_ff, rsp_in;

   plbo_pkg::ucode_type uw;
   logic       accept, tick, start_ok, at_right, span2, final_pass;
   logic [2:0] tp, bp, r1, r2, pg;
   logic [7:0] adr, corner, line, pix, byte_sel;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && req_data.mode && busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign uw       = plbo_pkg::ucode_rom(step_ff);
   assign tp       = top_ff[5:3];
   assign bp       = bottom_ff[5:3];
   assign r1       = top_ff[2:0];
   assign r2       = bottom_ff[2:0];
   assign at_right = (col_ff == right_ff);
   assign span2    = ({1'b0, bp} >= ({1'b0, tp} + 4'd2));

   assign start_ok = !busy_ff && (req_data.x_left < req_data.x_right)
                     && (req_data.y_top <= req_data.y_bottom)
                     && ({1'b0, req_data.x_right} < ColLimit)
                     && ({1'b0, req_data.y_bottom[5:3]} < PageLimit);

   always_comb begin
      if (span2) begin
         final_pass = (pass_ff == plbo_pkg::PASS_MID)
                      && (({1'b0, page_ff} + 4'd1) >= {1'b0, bp});
      end else if (bp != tp) begin
         final_pass = (pass_ff == plbo_pkg::PASS_BOTTOM);
      end else begin
         final_pass = 1'b1;
      end
   end

   // pixel column byte, top row in bit 7
   always_comb begin
      logic [7:0] top_mask, bot_mask;
      top_mask = plbo_pkg::ALL_ROWS >> r1;
      bot_mask = 8'(plbo_pkg::ALL_ROWS << (3'd7 - r2));
      case (pass_ff)
         plbo_pkg::PASS_TOP: begin
            if (tp == bp) begin
               corner = top_mask & bot_mask;
               line   = (plbo_pkg::TOP_BIT >> r1) | (plbo_pkg::TOP_BIT >> r2);
            end else begin
               corner = top_mask;
               line   = plbo_pkg::TOP_BIT >> r1;
            end
         end
         plbo_pkg::PASS_BOTTOM: begin
            corner = bot_mask;
            line   = plbo_pkg::TOP_BIT >> r2;
         end
         default: begin
            corner = plbo_pkg::ALL_ROWS;
            line   = '0;
         end
      endcase
      pix = ((col_ff == left_ff) || at_right) ? corner : line;
   end

   assign adr = {1'b0, left_ff} + (upside_ff ? plbo_pkg::FLIP_OFFSET : 8'd0);
   assign pg  = upside_ff ? (PageTop - page_ff) : page_ff;

   always_comb begin
      case (uw.sel)
         plbo_pkg::SEL_PAGE:   byte_sel = plbo_pkg::CMD_PAGE | {5'd0, pg};
         plbo_pkg::SEL_COL_HI: byte_sel = plbo_pkg::CMD_COL_HI
                                          | ((adr & plbo_pkg::NIB_HI) >> 4);
         plbo_pkg::SEL_COL_LO: byte_sel = adr & plbo_pkg::NIB_LO;
         default:              byte_sel = upside_ff ? pix : plbo_pkg::bit_reverse8(pix);
      endcase
   end

   always_comb begin
      upside_in    = csr_write_en ? csr_write_data : upside_ff;
      busy_in      = busy_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      pass_in      = pass_ff;
      page_in      = page_ff;
      step_in      = step_ff;
      col_in       = (step_ff == plbo_pkg::STEP_DATA) ? col_ff : left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (accept && !req_data.mode && start_ok) begin
         busy_in   = 1'b1;
         left_in   = req_data.x_left;
         right_in  = req_data.x_right;
         top_in    = req_data.y_top;
         bottom_in = req_data.y_bottom;
         pass_in   = plbo_pkg::PASS_TOP;
         page_in   = req_data.y_top[5:3];
         step_in   = plbo_pkg::STEP_PAGE;
      end

      if (tick) begin
         rsp_valid_in           = 1'b1;
         rsp_in.byte_out        = byte_sel;
         rsp_in.is_data         = uw.is_data;
         rsp_in.end_of_transfer = uw.eot || (uw.jump_at_right && at_right);
         rsp_in.last            = uw.jump_at_right && at_right && final_pass;
         step_in                = uw.next_step;
         if (uw.jump_at_right) begin
            col_in = col_ff + 7'd1;
         end
         if (uw.jump_at_right && at_right) begin
            step_in = plbo_pkg::STEP_PAGE;
            if (pass_ff == plbo_pkg::PASS_TOP && bp != tp) begin
               pass_in = plbo_pkg::PASS_BOTTOM;
               page_in = bp;
            end else if (pass_ff != plbo_pkg::PASS_MID && span2) begin
               pass_in = plbo_pkg::PASS_MID;
               page_in = tp + 3'd1;
            end else if (pass_ff == plbo_pkg::PASS_MID
                         && (({1'b0, page_ff} + 4'd1) < {1'b0, bp})) begin
               page_in = page_ff + 3'd1;
            end else begin
               busy_in = 1'b0;
               pass_in = plbo_pkg::PASS_TOP;
               page_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upside_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         pass_ff      <= plbo_pkg::PASS_TOP;
         page_ff      <= '0;
         step_ff      <= plbo_pkg::STEP_PAGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upside_ff    <= upside_in;
         busy_ff      <= busy_in;
         pass_ff      <= pass_in;
         page_ff      <= page_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
      col_ff    <= col_in;
      rsp_ff    <= rsp_in;
   end

   `PLBO_ASSERT_IMP(a_idle_at_page_step, clock, reset, !busy_ff, step_ff == plbo_pkg::STEP_PAGE)
   `PLBO_ASSERT_IMP(a_last_is_final_data, clock, reset, rsp_valid_ff && rsp_ff.last, rsp_ff.is_data && rsp_ff.end_of_transfer)
   `PLBO_ASSERT_NXT(a_idle_tick_silent, clock, reset, accept && !busy_ff, !rsp_valid_ff)
   `PLBO_ASSERT_IMP(a_col_in_box, clock, reset, busy_ff && step_ff == plbo_pkg::STEP_DATA, col_ff >= left_ff && col_ff <= right_ff)

endmodule
